// ===== hdl/lbu_pkg.sv =====
`default_nettype none

package lbu_pkg;

  localparam int TABLE_COLUMNS_DEF = 640;
  localparam int TABLE_ROWS_DEF    = 480;
  localparam int FRAC_BITS_DEF     = 8;

  localparam int PT_W       = 18;
  localparam int ADDR_IN_W  = 19;
  localparam int DATA_W     = 32;
  localparam int ACT_W_W    = 10;
  localparam int ACT_H_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int SCALE_SHIFT = 24;
  localparam int SAT_HI_BIT  = SCALE_SHIFT + DATA_W - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_FOCUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 2'd2;

  localparam logic signed [DATA_W-1:0] INV_FOCUS_RST = -32'sd16777216;
  localparam logic [ACT_W_W-1:0]       ACT_W_RST     = 10'd640;
  localparam logic [ACT_H_W-1:0]       ACT_H_RST     = 9'd480;

  localparam logic signed [2*DATA_W-1:0] SCALE_ROUND = 64'sd8388608;
  localparam logic signed [DATA_W-1:0]   SAT_MAX     = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0]   SAT_MIN     = 32'sh8000_0000;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                     mode;
    logic [ADDR_IN_W-1:0]      entry_address;
    logic signed [DATA_W-1:0]  entry_x;
    logic signed [DATA_W-1:0]  entry_y;
    logic [PT_W-1:0]           point_col;
    logic [PT_W-1:0]           point_row;
  } in_item_t;

  typedef struct packed {
    logic                      inside_res;
    logic signed [DATA_W-1:0]  norm_x;
    logic signed [DATA_W-1:0]  norm_y;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/lut_bilinear_undistort.sv =====
// Lens correction by table lookup: load transactions (mode 0) write one (x, y) entry of the
// correction table, query transactions (mode 1) return one result, the bilinear blend of the four
// neighboring entries scaled by the inverse focus, or inside_res 0 with zero coordinates for a
// point outside the active area. One transaction is accepted every cycle while in_stall is low;
// a query's result passes through the stage registers to the output register. The rate is set
// by the table storage: two identical copies of the table, each with one write port and two
// read ports, deliver all four neighbors together, and a load is visible to the query that
// directly follows it. in_stall is high only while a result waits at the output and out_stall is
// high. The table is not cleared after reset; an entry holds a defined value only once loaded.
`default_nettype none

module lut_bilinear_undistort #(
  parameter int TABLE_COLUMNS = lbu_pkg::TABLE_COLUMNS_DEF,
  parameter int TABLE_ROWS    = lbu_pkg::TABLE_ROWS_DEF,
  parameter int FRAC_BITS     = lbu_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lbu_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lbu_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [lbu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbu_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DEPTH  = TABLE_COLUMNS * TABLE_ROWS;
  localparam int AW     = $clog2(DEPTH);
  localparam int COL_W  = $clog2(TABLE_COLUMNS);
  localparam int ROW_W  = $clog2(TABLE_ROWS);
  localparam int LIM_CW = $clog2(TABLE_COLUMNS + 1);
  localparam int LIM_RW = $clog2(TABLE_ROWS + 1);
  localparam int DW     = lbu_pkg::DATA_W;
  localparam int IW     = lbu_pkg::PT_W - FRAC_BITS;
  localparam int FW     = FRAC_BITS + 1;
  localparam int WW     = 2 * FRAC_BITS + 2;
  localparam int PW     = DW + WW;
  localparam int SW     = PW + 2;
  localparam int SCALE  = 1 << FRAC_BITS;
  localparam int BSH    = 2 * FRAC_BITS;

  function automatic logic signed [DW-1:0] scale_sat(input logic signed [2*DW-1:0] p);
    logic signed [2*DW-1:0] q;
    logic                   fits;
    q    = p + lbu_pkg::SCALE_ROUND;
    fits = (q[2*DW-1:lbu_pkg::SAT_HI_BIT] == '0) || (q[2*DW-1:lbu_pkg::SAT_HI_BIT] == '1);
    if (fits) begin
      return q[lbu_pkg::SAT_HI_BIT:lbu_pkg::SCALE_SHIFT];
    end else if (q[2*DW-1]) begin
      return lbu_pkg::SAT_MIN;
    end else begin
      return lbu_pkg::SAT_MAX;
    end
  endfunction

  // configuration
  logic signed [DW-1:0]            inv_focus_r;
  logic [lbu_pkg::ACT_W_W-1:0]     act_w_r;
  logic [lbu_pkg::ACT_H_W-1:0]     act_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_focus_r <= lbu_pkg::INV_FOCUS_RST;
      act_w_r     <= lbu_pkg::ACT_W_RST;
      act_h_r     <= lbu_pkg::ACT_H_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lbu_pkg::CFG_INVERSE_FOCUS: inv_focus_r <= cfg_wdata[DW-1:0];
        lbu_pkg::CFG_ACTIVE_WIDTH:  act_w_r     <= cfg_wdata[lbu_pkg::ACT_W_W-1:0];
        lbu_pkg::CFG_ACTIVE_HEIGHT: act_h_r     <= cfg_wdata[lbu_pkg::ACT_H_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic advance;
  logic out_valid_r;
  lbu_pkg::out_item_t out_data_r;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  // front: split point, range check, clamp neighbors
  logic [IW-1:0]        cu_in, ru_in;
  logic [FRAC_BITS-1:0] fx_in, fy_in;
  logic [LIM_CW-1:0]    cols_lim;
  logic [LIM_RW-1:0]    rows_lim;
  logic                 inside1_nxt;
  logic [COL_W-1:0]     cu1_nxt, co1_nxt;
  logic [ROW_W-1:0]     ru1_nxt, ro1_nxt;

  assign cu_in = in_data.point_col[lbu_pkg::PT_W-1:FRAC_BITS];
  assign ru_in = in_data.point_row[lbu_pkg::PT_W-1:FRAC_BITS];
  assign fx_in = in_data.point_col[FRAC_BITS-1:0];
  assign fy_in = in_data.point_row[FRAC_BITS-1:0];

  assign cols_lim = (32'(act_w_r) < 32'(TABLE_COLUMNS)) ? LIM_CW'(act_w_r)
                                                        : LIM_CW'(TABLE_COLUMNS);
  assign rows_lim = (32'(act_h_r) < 32'(TABLE_ROWS)) ? LIM_RW'(act_h_r)
                                                     : LIM_RW'(TABLE_ROWS);

  assign inside1_nxt = (32'(cu_in) < 32'(cols_lim)) && (32'(ru_in) < 32'(rows_lim));
  assign cu1_nxt = COL_W'(cu_in);
  assign ru1_nxt = ROW_W'(ru_in);
  assign co1_nxt = (32'(cu_in) + 32'd1 < 32'(cols_lim)) ? COL_W'(32'(cu_in) + 32'd1)
                                                        : COL_W'(32'(cols_lim) - 32'd1);
  assign ro1_nxt = (32'(ru_in) + 32'd1 < 32'(rows_lim)) ? ROW_W'(32'(ru_in) + 32'd1)
                                                        : ROW_W'(32'(rows_lim) - 32'd1);

  // stage 1
  logic                 v1_r;
  lbu_pkg::in_item_t    item1_r;
  logic                 inside1_r;
  logic [COL_W-1:0]     cu1_r, co1_r;
  logic [ROW_W-1:0]     ru1_r, ro1_r;
  logic [FRAC_BITS-1:0] fx1_r, fy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item1_r   <= in_data;
      inside1_r <= inside1_nxt;
      cu1_r     <= cu1_nxt;
      co1_r     <= co1_nxt;
      ru1_r     <= ru1_nxt;
      ro1_r     <= ro1_nxt;
      fx1_r     <= fx_in;
      fy1_r     <= fy_in;
    end
  end

  // table addresses, weights and write port
  logic [AW-1:0]  a00, a01, a10, a11, wr_addr;
  logic [31:0]    base_r, base_o;
  logic           wr_en;
  logic [2*DW-1:0] wr_data;
  logic [FW-1:0]  sfx, sfy, fxe, fye;
  logic [WW-1:0]  w00_nxt, w01_nxt, w10_nxt, w11_nxt;
  logic           q1;

  assign base_r = 32'(ru1_r) * 32'(TABLE_COLUMNS);
  assign base_o = 32'(ro1_r) * 32'(TABLE_COLUMNS);
  assign a00 = AW'(base_r + 32'(cu1_r));
  assign a01 = AW'(base_r + 32'(co1_r));
  assign a10 = AW'(base_o + 32'(cu1_r));
  assign a11 = AW'(base_o + 32'(co1_r));

  assign q1      = v1_r && (item1_r.mode == lbu_pkg::MODE_QUERY);
  assign wr_en   = v1_r && (item1_r.mode == lbu_pkg::MODE_LOAD) && advance &&
                   (32'(item1_r.entry_address) < 32'(DEPTH));
  assign wr_addr = AW'(item1_r.entry_address);
  assign wr_data = {item1_r.entry_y, item1_r.entry_x};

  assign fxe = FW'(fx1_r);
  assign fye = FW'(fy1_r);
  assign sfx = FW'(SCALE) - fxe;
  assign sfy = FW'(SCALE) - fye;
  assign w00_nxt = WW'(sfx) * WW'(sfy);
  assign w01_nxt = WW'(fxe) * WW'(sfy);
  assign w10_nxt = WW'(sfx) * WW'(fye);
  assign w11_nxt = WW'(fxe) * WW'(fye);

  // two copies of the table: upper row pair and lower row pair
  logic [2*DW-1:0] mem_a_r [DEPTH];
  logic [2*DW-1:0] mem_b_r [DEPTH];
  logic [2*DW-1:0] d00_r, d01_r, d10_r, d11_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a_r[wr_addr] <= wr_data;
    end
    if (advance) begin
      d00_r <= mem_a_r[a00];
      d01_r <= mem_a_r[a01];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_b_r[wr_addr] <= wr_data;
    end
    if (advance) begin
      d10_r <= mem_b_r[a10];
      d11_r <= mem_b_r[a11];
    end
  end

  // stage 2
  logic          v2_r, inside2_r;
  logic [WW-1:0] w00_r, w01_r, w10_r, w11_r;

  // stage 3: weighted products
  logic          v3_r, inside3_r;
  logic signed [PW-1:0] px00_r, px01_r, px10_r, px11_r;
  logic signed [PW-1:0] py00_r, py01_r, py10_r, py11_r;

  // stage 4: pair sums
  logic          v4_r, inside4_r;
  logic signed [SW-1:0] sxa_r, sxb_r, sya_r, syb_r;

  // stage 5: rounded blend
  logic          v5_r, inside5_r;
  logic signed [DW-1:0] ix_r, iy_r;
  logic signed [SW-1:0] sx_nxt, sy_nxt;

  // stage 6: focus scaling
  logic          v6_r, inside6_r;
  logic signed [2*DW-1:0] prx_r, pry_r;

  assign sx_nxt = sxa_r + sxb_r + (SW'(1) <<< (BSH - 1));
  assign sy_nxt = sya_r + syb_r + (SW'(1) <<< (BSH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v2_r <= q1;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      inside2_r <= inside1_r;
      w00_r     <= w00_nxt;
      w01_r     <= w01_nxt;
      w10_r     <= w10_nxt;
      w11_r     <= w11_nxt;

      inside3_r <= inside2_r;
      px00_r <= PW'($signed(d00_r[DW-1:0])) * PW'($signed(w00_r));
      px01_r <= PW'($signed(d01_r[DW-1:0])) * PW'($signed(w01_r));
      px10_r <= PW'($signed(d10_r[DW-1:0])) * PW'($signed(w10_r));
      px11_r <= PW'($signed(d11_r[DW-1:0])) * PW'($signed(w11_r));
      py00_r <= PW'($signed(d00_r[2*DW-1:DW])) * PW'($signed(w00_r));
      py01_r <= PW'($signed(d01_r[2*DW-1:DW])) * PW'($signed(w01_r));
      py10_r <= PW'($signed(d10_r[2*DW-1:DW])) * PW'($signed(w10_r));
      py11_r <= PW'($signed(d11_r[2*DW-1:DW])) * PW'($signed(w11_r));

      inside4_r <= inside3_r;
      sxa_r <= SW'(px00_r) + SW'(px01_r);
      sxb_r <= SW'(px10_r) + SW'(px11_r);
      sya_r <= SW'(py00_r) + SW'(py01_r);
      syb_r <= SW'(py10_r) + SW'(py11_r);

      inside5_r <= inside4_r;
      ix_r <= sx_nxt[BSH+DW-1:BSH];
      iy_r <= sy_nxt[BSH+DW-1:BSH];

      inside6_r <= inside5_r;
      prx_r <= (2*DW)'(ix_r) * (2*DW)'(inv_focus_r);
      pry_r <= (2*DW)'(iy_r) * (2*DW)'(inv_focus_r);

      if (inside6_r) begin
        out_data_r.inside_res <= 1'b1;
        out_data_r.norm_x     <= scale_sat(prx_r);
        out_data_r.norm_y     <= scale_sat(pry_r);
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.inside_res) |-> (out_data.norm_x == '0 && out_data.norm_y == '0))
    else $error("outside point gave nonzero coordinates");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && item1_r.mode == lbu_pkg::MODE_LOAD && advance) |=> !v2_r)
    else $error("load transaction entered the result path");

  a_query_flows: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && item1_r.mode == lbu_pkg::MODE_QUERY && advance) |=> v2_r)
    else $error("query transaction dropped");

endmodule

`default_nettype wire
